// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL back end (tpb_back.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: hw/rtl/tpb_pkg.sv
// Shared constants, types and helpers of the tagged packet buffer.
package tpb_pkg;
   localparam int NODES       = 8;
   localparam int NODE_W      = $clog2(NODES);
   localparam int CNT_W       = $clog2(NODES + 1);
   localparam int MAX_LEN     = 20;
   localparam int LEN_W       = 5;
   localparam int PIPE_W      = 8;
   localparam int BYTE_W      = 8;
   localparam int DATA_DEPTH  = NODES * MAX_LEN;
   localparam int ADDR_W      = $clog2(DATA_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_RX         = 3'd0,
      OP_READ       = 3'd1,
      OP_READ_PIPE  = 3'd2,
      OP_PEEK       = 3'd3,
      OP_PEEK_PIPE  = 3'd4,
      OP_FLUSH      = 3'd5,
      OP_FLUSH_PIPE = 3'd6,
      OP_COUNT      = 3'd7
   } opcode_type;

   // Classified command handed from front to back
   typedef struct packed {
      opcode_type          op;
      logic                any_pipe;
      logic                removing;
      logic [PIPE_W-1:0]   pipe;
      logic [BYTE_W-1:0]   rx_byte;
   } cmd_type;

   // Address of one data byte of a node in the data store
   function automatic logic [ADDR_W-1:0] data_addr(logic [NODE_W-1:0] node,
                                                   logic [LEN_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(node) * ADDR_W'(MAX_LEN);
      return base + ADDR_W'(idx);
   endfunction
endpackage

// File: hw/rtl/tpb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/tpb_front.sv
// Front end: accepts request transfers, classifies them, queues commands.
module tpb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_opcode,
   input  logic [7:0]            req_pipe,
   input  logic [7:0]            req_rx_byte,
   output logic                  cmd_valid,
   output tpb_pkg::cmd_type      cmd,
   input  logic                  cmd_pop
);
   import tpb_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             dec;
   logic                push;

   // Classify the opcode
   always_comb begin
      dec.op       = opcode_type'(req_opcode);
      dec.pipe     = req_pipe;
      dec.rx_byte  = req_rx_byte;
      dec.any_pipe = 1'b0;
      dec.removing = 1'b0;
      case (dec.op) inside
         OP_READ, OP_PEEK:      dec.any_pipe = 1'b1;
         default:               dec.any_pipe = 1'b0;
      endcase
      case (dec.op) inside
         OP_READ, OP_READ_PIPE: dec.removing = 1'b1;
         default:               dec.removing = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule

// File: hw/rtl/tpb_back.sv
// Back end: frame receiver, linked node store, list walker, result output.
module tpb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  tpb_pkg::cmd_type             cmd,
   output logic                         cmd_pop,
   input  logic                         csr_wr_en,
   input  logic [7:0]                   csr_wr_data,
   output logic                         ram_we,
   output logic [tpb_pkg::ADDR_W-1:0]   ram_waddr,
   output logic [7:0]                   ram_wdata,
   output logic                         ram_re,
   output logic [tpb_pkg::ADDR_W-1:0]   ram_raddr,
   input  logic [7:0]                   ram_rdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [7:0]                   rsp_out_pipe,
   output logic [4:0]                   rsp_out_length,
   output logic [7:0]                   rsp_data_byte,
   output logic [4:0]                   rsp_byte_index,
   output logic                         rsp_last,
   output logic [3:0]                   rsp_total_count,
   output logic [3:0]                   rsp_pipe_count,
   output logic                         rsp_overflow,
   output logic                         rsp_connected
);
   import tpb_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE, ST_WALK, ST_STORE, ST_COPY, ST_EM_RD, ST_EM_OUT, ST_RESP
   } state_type;

   typedef enum logic [1:0] {RX_PIPE, RX_LEN, RX_DATA} rx_phase_type;

   // Control state
   state_type           state_ff, state_in;
   rx_phase_type        rx_phase_ff, rx_phase_in;
   logic [LEN_W-1:0]    rx_idx_ff, rx_idx_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [NODE_W-1:0]   head_ff, head_in;
   logic [NODE_W-1:0]   tail_ff, tail_in;
   logic                ovf_ff, ovf_in;
   logic                conn_ff, conn_in;
   logic [PIPE_W-1:0]   conn_pipe_ff, conn_pipe_in;
   logic [NODE_W-1:0]   free_ff [NODES];
   logic [NODE_W-1:0]   free_in [NODES];
   logic                rsp_valid_ff, rsp_valid_in;

   // Node and staging payload
   logic [PIPE_W-1:0]   node_pipe_ff [NODES];
   logic [PIPE_W-1:0]   node_pipe_in [NODES];
   logic [LEN_W-1:0]    node_len_ff  [NODES];
   logic [LEN_W-1:0]    node_len_in  [NODES];
   logic [NODE_W-1:0]   node_next_ff [NODES];
   logic [NODE_W-1:0]   node_next_in [NODES];
   logic [PIPE_W-1:0]   stg_pipe_ff, stg_pipe_in;
   logic [LEN_W-1:0]    stg_len_ff, stg_len_in;
   logic [BYTE_W-1:0]   stg_data_ff [MAX_LEN];
   logic [BYTE_W-1:0]   stg_data_in [MAX_LEN];

   // Walk and output payload
   cmd_type             cmd_ff, cmd_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [LEN_W-1:0]    byte_ff, byte_in;
   logic                r_found_ff, r_found_in;
   logic [PIPE_W-1:0]   r_pipe_ff, r_pipe_in;
   logic [LEN_W-1:0]    r_len_ff, r_len_in;
   logic [BYTE_W-1:0]   r_data_ff, r_data_in;
   logic [LEN_W-1:0]    r_idx_ff, r_idx_in;
   logic                r_last_ff, r_last_in;
   logic [CNT_W-1:0]    r_total_ff, r_total_in;
   logic [CNT_W-1:0]    r_pcount_ff, r_pcount_in;
   logic                r_ovf_ff, r_ovf_in;
   logic                r_conn_ff, r_conn_in;

   logic                match;
   logic [NODE_W-1:0]   nxt;
   logic [NODE_W-1:0]   prev_eff;
   logic                do_unlink;
   logic [NODE_W-1:0]   new_node;
   logic [LEN_W-1:0]    hit_len;
   logic                last_byte;

   assign match    = cmd_ff.any_pipe || (node_pipe_ff[cur_ff] == cmd_ff.pipe);
   assign nxt      = node_next_ff[cur_ff];
   assign prev_eff = (cur_ff == head_ff) ? cur_ff : prev_ff;
   assign hit_len  = node_len_ff[cur_ff];
   assign last_byte = (byte_ff == node_len_ff[node_ff] - 1'b1);

   always_comb begin
      state_in     = state_ff;
      rx_phase_in  = rx_phase_ff;
      rx_idx_in    = rx_idx_ff;
      used_in      = used_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      ovf_in       = ovf_ff;
      conn_in      = conn_ff;
      conn_pipe_in = conn_pipe_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff;
      node_pipe_in = node_pipe_ff;
      node_len_in  = node_len_ff;
      node_next_in = node_next_ff;
      stg_pipe_in  = stg_pipe_ff;
      stg_len_in   = stg_len_ff;
      stg_data_in  = stg_data_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      step_in      = step_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      node_in      = node_ff;
      byte_in      = byte_ff;
      r_found_in   = r_found_ff;
      r_pipe_in    = r_pipe_ff;
      r_len_in     = r_len_ff;
      r_data_in    = r_data_ff;
      r_idx_in     = r_idx_ff;
      r_last_in    = r_last_ff;
      r_total_in   = r_total_ff;
      r_pcount_in  = r_pcount_ff;
      r_ovf_in     = r_ovf_ff;
      r_conn_in    = r_conn_ff;
      cmd_pop      = 1'b0;
      do_unlink    = 1'b0;
      new_node     = free_ff[used_ff[NODE_W-1:0]];
      ram_we       = 1'b0;
      ram_waddr    = data_addr(node_ff, byte_ff);
      ram_wdata    = stg_data_ff[byte_ff];
      ram_re       = 1'b0;
      ram_raddr    = data_addr(node_ff, byte_ff);

      // Result slot drains on transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         conn_pipe_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (!rsp_valid_ff || rsp_ready)) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               cnt_in   = '0;
               cur_in   = head_ff;
               prev_in  = head_ff;
               step_in  = '0;
               limit_in = used_ff;
               state_in = ST_RESP;
               case (cmd.op)
                  OP_RX: begin
                     unique case (rx_phase_ff)
                        RX_PIPE: begin
                           stg_pipe_in = cmd.rx_byte;
                           rx_phase_in = RX_LEN;
                        end
                        RX_LEN: begin
                           if (cmd.rx_byte == '0 || cmd.rx_byte > BYTE_W'(MAX_LEN)) begin
                              rx_phase_in = RX_PIPE;
                           end else begin
                              stg_len_in  = cmd.rx_byte[LEN_W-1:0];
                              rx_idx_in   = '0;
                              rx_phase_in = RX_DATA;
                           end
                        end
                        RX_DATA: begin
                           if (rx_idx_ff >= stg_len_ff) begin
                              rx_phase_in = RX_PIPE;
                           end else begin
                              stg_data_in[rx_idx_ff] = cmd.rx_byte;
                              if (rx_idx_ff == '0 && stg_pipe_ff == conn_pipe_ff) begin
                                 conn_in = (cmd.rx_byte != '0);
                              end
                              rx_idx_in = rx_idx_ff + 1'b1;
                              if (rx_idx_ff + 1'b1 >= stg_len_ff) begin
                                 rx_phase_in = RX_PIPE;
                                 if (stg_pipe_ff != '0) begin
                                    state_in = ST_STORE;
                                 end
                              end
                           end
                        end
                        default: rx_phase_in = RX_PIPE;
                     endcase
                  end
                  OP_FLUSH: begin
                     for (int i = 0; i < NODES; i++) begin
                        free_in[i] = NODE_W'(i);
                     end
                     used_in = '0;
                     head_in = '0;
                     tail_in = '0;
                     ovf_in  = 1'b0;
                  end
                  default: begin
                     if (cmd.op == OP_READ) begin
                        ovf_in = 1'b0;
                     end
                     state_in = ST_WALK;
                  end
               endcase
            end
         end

         // One linked node per cycle
         ST_WALK: begin
            if (step_ff == limit_ff) begin
               state_in = ST_RESP;
            end else begin
               cur_in  = nxt;
               step_in = step_ff + 1'b1;
               case (cmd_ff.op)
                  OP_COUNT: begin
                     cnt_in = cnt_ff + CNT_W'(match);
                  end
                  OP_FLUSH_PIPE: begin
                     if (match) begin
                        ovf_in    = 1'b0;
                        do_unlink = 1'b1;
                     end else begin
                        prev_in = cur_ff;
                     end
                  end
                  default: begin
                     if (match) begin
                        node_in = cur_ff;
                        byte_in = '0;
                        if (cmd_ff.removing) begin
                           ovf_in    = 1'b0;
                           do_unlink = 1'b1;
                        end
                        if (hit_len == '0 || hit_len > LEN_W'(MAX_LEN)) begin
                           state_in = ST_RESP;
                        end else begin
                           state_in = ST_EM_RD;
                        end
                     end else begin
                        prev_in = cur_ff;
                     end
                  end
               endcase
            end
         end

         // Allocate a node (the oldest one when the store is full) and append it at the tail
         ST_STORE: begin
            if (used_ff >= CNT_W'(NODES)) begin
               new_node = head_ff;
               head_in  = node_next_ff[head_ff];
               ovf_in   = 1'b1;
               used_in  = CNT_W'(NODES);
               node_next_in[tail_ff] = new_node;
            end else begin
               used_in = used_ff + 1'b1;
               if (used_ff == '0) begin
                  head_in = new_node;
               end else begin
                  node_next_in[tail_ff] = new_node;
               end
            end
            node_next_in[new_node] = new_node;
            node_pipe_in[new_node] = stg_pipe_ff;
            node_len_in[new_node]  = stg_len_ff;
            tail_in  = new_node;
            node_in  = new_node;
            byte_in  = '0;
            state_in = ST_COPY;
         end

         // Copy staged bytes into the data store
         ST_COPY: begin
            ram_we  = 1'b1;
            byte_in = byte_ff + 1'b1;
            if (byte_ff == stg_len_ff - 1'b1) begin
               state_in = ST_RESP;
            end
         end

         ST_EM_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ram_re   = 1'b1;
               state_in = ST_EM_OUT;
            end
         end

         ST_EM_OUT: begin
            rsp_valid_in = 1'b1;
            r_found_in   = 1'b1;
            r_pipe_in    = node_pipe_ff[node_ff];
            r_len_in     = node_len_ff[node_ff];
            r_data_in    = ram_rdata;
            r_idx_in     = byte_ff;
            r_last_in    = last_byte;
            r_total_in   = used_ff;
            r_pcount_in  = '0;
            r_ovf_in     = ovf_ff;
            r_conn_in    = conn_ff;
            byte_in      = byte_ff + 1'b1;
            state_in     = last_byte ? ST_IDLE : ST_EM_RD;
         end

         // Single status result
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            r_found_in   = 1'b0;
            r_pipe_in    = '0;
            r_len_in     = '0;
            r_data_in    = '0;
            r_idx_in     = '0;
            r_last_in    = 1'b1;
            r_total_in   = used_ff;
            r_pcount_in  = cnt_ff;
            r_ovf_in     = ovf_ff;
            r_conn_in    = conn_ff;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      // Unlink the current node and push it on the free stack
      if (do_unlink) begin
         if (cur_ff == head_ff) begin
            head_in = nxt;
         end else begin
            node_next_in[prev_eff] = nxt;
         end
         if (cur_ff == tail_ff) begin
            tail_in = prev_eff;
         end
         if (used_ff != '0) begin
            used_in = used_ff - 1'b1;
            free_in[NODE_W'(used_ff - 1'b1)] = cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rx_phase_ff  <= RX_PIPE;
         rx_idx_ff    <= '0;
         used_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         ovf_ff       <= 1'b0;
         conn_ff      <= 1'b0;
         conn_pipe_ff <= PIPE_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            free_ff[i] <= NODE_W'(i);
         end
      end else begin
         state_ff     <= state_in;
         rx_phase_ff  <= rx_phase_in;
         rx_idx_ff    <= rx_idx_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         ovf_ff       <= ovf_in;
         conn_ff      <= conn_in;
         conn_pipe_ff <= conn_pipe_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      node_pipe_ff <= node_pipe_in;
      node_len_ff  <= node_len_in;
      node_next_ff <= node_next_in;
      stg_pipe_ff  <= stg_pipe_in;
      stg_len_ff   <= stg_len_in;
      stg_data_ff  <= stg_data_in;
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      step_ff      <= step_in;
      limit_ff     <= limit_in;
      cnt_ff       <= cnt_in;
      node_ff      <= node_in;
      byte_ff      <= byte_in;
      r_found_ff   <= r_found_in;
      r_pipe_ff    <= r_pipe_in;
      r_len_ff     <= r_len_in;
      r_data_ff    <= r_data_in;
      r_idx_ff     <= r_idx_in;
      r_last_ff    <= r_last_in;
      r_total_ff   <= r_total_in;
      r_pcount_ff  <= r_pcount_in;
      r_ovf_ff     <= r_ovf_in;
      r_conn_ff    <= r_conn_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = r_found_ff;
   assign rsp_out_pipe    = r_pipe_ff;
   assign rsp_out_length  = r_len_ff;
   assign rsp_data_byte   = r_data_ff;
   assign rsp_byte_index  = r_idx_ff;
   assign rsp_last        = r_last_ff;
   assign rsp_total_count = r_total_ff;
   assign rsp_pipe_count  = r_pcount_ff;
   assign rsp_overflow    = r_ovf_ff;
   assign rsp_connected   = r_conn_ff;

   `ASSERT_NEVER(a_used_max, clock, reset, used_ff > CNT_W'(NODES))
   `ASSERT_CLK(a_single_head_tail, clock, reset, (used_ff == CNT_W'(1)) |-> (head_ff == tail_ff))
   `ASSERT_CLK(a_out_after_read, clock, reset, (state_ff == ST_EM_OUT) |-> ($past(state_ff) == ST_EM_RD))
endmodule

// File: hw/rtl/pipe_tagged_packet_buffer.sv
// Top level of the tagged packet buffer: front end, back end and data store.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | opcode, pipe, rx_byte
//  rsp     | out       | rsp_valid/rsp_ready  | found .. connected
//  csr     | in        | csr_wr_en            | connected_pipe
//
// A link byte returns one status result; the byte that completes a stored frame with a
// nonzero pipe first allocates a node and copies the bytes into the data store.
// Flush returns one status result; read, peek, per-pipe flush and count walk one linked
// node per cycle (up to 8); each returned data byte is read from the data store once the
// result slot is free and is output after the registered read.
// Reset is synchronous; it empties the store and the 2-entry command queue.
// A stalled result holds the back end; the front keeps queueing commands until its queue is full.
module pipe_tagged_packet_buffer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_pipe,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_out_pipe,
   output logic [4:0] rsp_out_length,
   output logic [7:0] rsp_data_byte,
   output logic [4:0] rsp_byte_index,
   output logic       rsp_last,
   output logic [3:0] rsp_total_count,
   output logic [3:0] rsp_pipe_count,
   output logic       rsp_overflow,
   output logic       rsp_connected,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import tpb_pkg::*;

   cmd_type             cmd;
   logic                cmd_valid;
   logic                cmd_pop;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [7:0]          ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [7:0]          ram_rdata;

   tpb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_pipe    (req_pipe),
      .req_rx_byte (req_rx_byte),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   tpb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DATA_DEPTH)
   ) u_data (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tpb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_re          (ram_re),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_out_pipe    (rsp_out_pipe),
      .rsp_out_length  (rsp_out_length),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last        (rsp_last),
      .rsp_total_count (rsp_total_count),
      .rsp_pipe_count  (rsp_pipe_count),
      .rsp_overflow    (rsp_overflow),
      .rsp_connected   (rsp_connected)
   );
endmodule
